// ===== src/seven_bit_frame_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// seven_bit_frame_receiver_macros
// assertion macros shared by the receiver modules
// ----------------------------------------------------------------------------
`ifndef SEVEN_BIT_FRAME_RECEIVER_MACROS_SVH
`define SEVEN_BIT_FRAME_RECEIVER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled while in reset
`define SBFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while in reset
`define SBFR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SBFR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define SBFR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/sbfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbfr_pkg
// types and constants of the seven-bit frame receiver
// ----------------------------------------------------------------------------
package sbfr_pkg;

    localparam int RESULT_CAP     = 4;   // most result items one input item can cause
    localparam int CNT_W          = 3;   // holds 0 .. RESULT_CAP
    localparam int WORD_BYTES_DEF = 4;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_LEN   = 2'd1,
        PH_DATA  = 2'd2,
        PH_CHECK = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       frame_ok;
    } res_t;

    // results caused by one input item, item[0] goes out first
    typedef struct packed {
        res_t [RESULT_CAP-1:0] item;
        logic [CNT_W-1:0]      cnt;
    } batch_t;

endpackage

// ===== src/sbfr_decode.sv =====
// ----------------------------------------------------------------------------
// sbfr_decode
// frame state machine, checksum and 7-to-8 bit repacking
// ----------------------------------------------------------------------------
module sbfr_decode
    import sbfr_pkg::*;
#(
    parameter int WORD_BYTES = WORD_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] rx_byte,
    input  logic       pad_to_word,
    output batch_t     batch
);

`include "seven_bit_frame_receiver_macros.svh"

    localparam int EW = $clog2(WORD_BYTES + 1);
    localparam int MW = (EW + 1 > CNT_W) ? EW + 1 : CNT_W;

    phase_t        phase_reg, phase_next;
    logic [7:0]    left_reg, left_next;
    logic [7:0]    sum_reg, sum_next;
    logic [14:0]   acc_reg, acc_next;
    logic [2:0]    held_reg, held_next;
    logic          sign_reg, sign_next;
    logic [EW-1:0] emitted_reg, emitted_next;
    logic          saw_reg, saw_next;

    // payload path
    logic [7:0]  sum_add;
    logic [14:0] acc_ins;
    logic [3:0]  held_add;
    // checksum path
    logic [6:0]  expect_sum;
    logic        tail;
    logic [7:0]  fill;
    logic [7:0]  tail_byte;
    logic [MW-1:0] emit_t, rem, avail, npad, k;

    assign sum_add  = sum_reg + rx_byte;
    assign acc_ins  = acc_reg | ({8'd0, rx_byte[6:0]} << held_reg);
    assign held_add = {1'b0, held_reg} + 4'd7;

    assign expect_sum = 7'(8'd0 - sum_reg);
    assign tail       = (held_reg != 3'd0);
    assign fill       = (pad_to_word && sign_reg) ? 8'hFF : 8'h00;
    assign tail_byte  = acc_reg[7:0] | 8'(fill << held_reg);
    assign emit_t     = MW'(emitted_reg) + MW'(tail);
    assign rem        = (pad_to_word && emit_t < MW'(WORD_BYTES)) ?
                        MW'(WORD_BYTES) - emit_t : '0;
    assign avail      = MW'(RESULT_CAP) - MW'(tail);
    assign npad       = (rem < avail) ? rem : avail;
    assign k          = MW'(tail) + npad;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        sum_next     = sum_reg;
        acc_next     = acc_reg;
        held_next    = held_reg;
        sign_next    = sign_reg;
        emitted_next = emitted_reg;
        saw_next     = saw_reg;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte[7])
                    begin
                        sum_next   = rx_byte;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    sum_next     = sum_add;
                    left_next    = rx_byte;
                    acc_next     = '0;
                    held_next    = '0;
                    sign_next    = 1'b0;
                    emitted_next = '0;
                    saw_next     = 1'b0;
                    phase_next   = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA:
                begin
                    sum_next  = sum_add;
                    saw_next  = 1'b1;
                    sign_next = rx_byte[6];
                    if (held_add[3])
                    begin
                        acc_next  = {8'd0, acc_ins[14:8]};
                        held_next = held_add[2:0];
                        if (emitted_reg < EW'(WORD_BYTES))
                            emitted_next = emitted_reg + 1'b1;
                    end
                    else
                    begin
                        acc_next  = acc_ins;
                        held_next = held_add[2:0];
                    end
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                        phase_next = PH_CHECK;
                end
                PH_CHECK:
                begin
                    phase_next = PH_HUNT;
                    if (rx_byte == {1'b0, expect_sum} && saw_reg)
                        emitted_next = (emit_t + npad > MW'(WORD_BYTES)) ?
                                       EW'(WORD_BYTES) : EW'(emit_t + npad);
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    // result items
    always_comb
    begin
        batch = '0;
        unique case (phase_reg)
            PH_DATA:
            begin
                if (held_add[3])
                begin
                    batch.cnt                 = CNT_W'(1);
                    batch.item[0].out_byte    = acc_ins[7:0];
                    batch.item[0].byte_valid  = 1'b1;
                end
            end
            PH_CHECK:
            begin
                batch.cnt = CNT_W'(1);
                if (rx_byte != {1'b0, expect_sum})
                    batch.item[0].frame_end = 1'b1;
                else if (!saw_reg || k == '0)
                begin
                    batch.item[0].frame_end = 1'b1;
                    batch.item[0].frame_ok  = 1'b1;
                end
                else
                begin
                    batch.cnt = CNT_W'(k);
                    for (int i = 0; i < RESULT_CAP; i++)
                    begin
                        batch.item[i].out_byte   = (i == 0 && tail) ? tail_byte : fill;
                        batch.item[i].byte_valid = (MW'(i) < k);
                        batch.item[i].frame_end  = (MW'(i) == k - 1'b1);
                        batch.item[i].frame_ok   = (MW'(i) == k - 1'b1);
                    end
                end
            end
            default: batch = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            left_reg    <= '0;
            sum_reg     <= '0;
            acc_reg     <= '0;
            held_reg    <= '0;
            sign_reg    <= 1'b0;
            emitted_reg <= '0;
            saw_reg     <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            sum_reg     <= sum_next;
            acc_reg     <= acc_next;
            held_reg    <= held_next;
            sign_reg    <= sign_next;
            emitted_reg <= emitted_next;
            saw_reg     <= saw_next;
        end
    end

    // a data phase always has payload bytes still to come
    `SBFR_ASSERT_IMP(a_data_left, clk, rst_n, phase_reg == PH_DATA, left_reg != 8'd0,
        "data phase with no payload left")
    // only the checksum byte can cause more than one result
    `SBFR_ASSERT_IMP(a_multi_check, clk, rst_n, batch.cnt > CNT_W'(1),
        phase_reg == PH_CHECK, "several results outside checksum phase")

endmodule

// ===== src/sbfr_outbuf.sv =====
// ----------------------------------------------------------------------------
// sbfr_outbuf
// result register holding one batch, drained one item per cycle while m_tready is high
// ----------------------------------------------------------------------------
module sbfr_outbuf
    import sbfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  batch_t     batch,
    output logic       can_load,
    output logic       m_tvalid,
    input  logic       m_tready,
    output res_t       head
);

`include "seven_bit_frame_receiver_macros.svh"

    res_t [RESULT_CAP-1:0] item_reg, item_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  take;

    assign m_tvalid = (cnt_reg != '0);
    assign take     = m_tvalid && m_tready;
    assign can_load = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && m_tready);
    assign head     = item_reg[0];

    always_comb
    begin
        item_next = item_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            item_next = batch.item;
            cnt_next  = batch.cnt;
        end
        else if (take)
        begin
            for (int i = 0; i < RESULT_CAP - 1; i++)
                item_next[i] = item_reg[i+1];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    `SBFR_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(RESULT_CAP),
        "result count beyond capacity")
    // the frame's last item is always the last one held
    `SBFR_ASSERT_IMP(a_end_last, clk, rst_n, m_tvalid && item_reg[0].frame_end,
        cnt_reg == CNT_W'(1), "frame end item not last in buffer")
    `SBFR_ASSERT_NXT(a_load_shows, clk, rst_n, load && batch.cnt != '0,
        m_tvalid, "loaded results not presented")

endmodule

// ===== src/seven_bit_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// seven_bit_frame_receiver
// deframer for 7-bit packed serial frames with checksum and word padding
// ----------------------------------------------------------------------------
// Takes one received byte per item. Frames are a start byte (bit 7 set), a
// length byte, that many 7-bit payload bytes and a checksum byte (negated
// 8-bit sum of start, length and payload, low 7 bits). Payload bits are
// repacked lsb first into 8-bit bytes that go out as soon as each is full.
// The checksum byte emits the tail byte and, with pad_to_word set, sign-filled
// padding up to WORD_BYTES bytes; an empty frame gives one status item and a
// checksum mismatch one error item (frame_ok low), after which already
// delivered bytes of that frame are to be discarded. Rate: one item per clock
// while each causes at most one result and the output is ready; a checksum
// byte causes up to four results, and the next item waits until the output
// buffer has drained down to its last entry and that entry is being taken.
// The first result of an item is presented in the cycle after it is taken.
module seven_bit_frame_receiver
    import sbfr_pkg::*;
#(
    parameter int WORD_BYTES = WORD_BYTES_DEF   // 1 .. 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] rx_byte, [8] pad_to_word, rest zero
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic [1:0]  m_tuser,    // [0] byte_valid, [1] frame_ok
    output logic        m_tlast     // frame_end
);

    batch_t batch;
    res_t   head;
    logic   can_load;
    logic   in_fire;

    // an item is taken whenever the buffer is empty or empties this cycle
    assign s_tready = can_load;
    assign in_fire  = s_tvalid && s_tready;

    sbfr_decode #(
        .WORD_BYTES (WORD_BYTES)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .rx_byte     (s_tdata[7:0]),
        .pad_to_word (s_tdata[8]),
        .batch       (batch)
    );

    // results of one item are loaded together and shifted out in order
    sbfr_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_fire),
        .batch    (batch),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    assign m_tdata = head.out_byte;
    assign m_tuser = {head.frame_ok, head.byte_valid};
    assign m_tlast = head.frame_end;

endmodule

// ===== tb/seven_bit_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_bit_frame_receiver_tb
// self-checking bench for the seven-bit frame receiver
// ----------------------------------------------------------------------------
// Feeds received bytes into the deframer and keeps its own decoder of the
// frame format in step with every item taken. Each result item is checked
// against the oldest decoded byte waiting. Directed frames cover noise,
// empty frames, sign fill and exact byte multiples. Random frames, noise and
// broken frames follow under several idle and stall mixes, then a long
// output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module seven_bit_frame_receiver_tb;
    import sbfr_pkg::*;

    typedef logic [7:0] byte_q_t [$];

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;    // [7:0] rx_byte, [8] pad_to_word
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] out_byte
    logic [1:0]  m_tuser;            // [0] byte_valid, [1] frame_ok
    logic        m_tlast;            // frame_end

    // idle mix, in percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // long output hold-off, in cycles, counted down by the receiver process
    int hold_left      = 0;

    // decoder state, mirrors the frame format
    phase_t      rx_phase    = PH_HUNT;
    logic [7:0]  run_sum     = 8'd0;
    logic [7:0]  bytes_left  = 8'd0;
    logic [14:0] bit_acc     = 15'd0;
    logic [2:0]  bits_in_acc = 3'd0;
    logic        sign_bit    = 1'b0;
    int          word_fill   = 0;    // bytes out so far, saturates at WORD_BYTES_DEF
    logic        got_payload = 1'b0;

    res_t decoded_q [$];

    int n_items    = 0;
    int n_checked  = 0;
    int n_frames   = 0;
    int n_bad_sums = 0;
    int n_fail     = 0;

    seven_bit_frame_receiver #(
        .WORD_BYTES (WORD_BYTES_DEF)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("seven_bit_frame_receiver: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // decoder
    // ------------------------------------------------------------------
    function automatic void push_decoded(input logic [7:0] b, input logic v,
                                         input logic e, input logic ok);
        res_t r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.frame_end  = e;
        r.frame_ok   = ok;
        decoded_q = {decoded_q, r};
    endfunction

    // advances the decoder by one received byte, queues the bytes it yields;
    // returns 0 when the byte is dropped while hunting
    function automatic bit deframe_step(input logic [7:0] b, input logic pad);
        logic [7:0] want;
        logic [7:0] fill;
        logic [7:0] outb [RESULT_CAP];
        int         held_now;
        int         emitted;
        int         k;
        int         i;
        bit         used;
        used = 1'b1;
        case (rx_phase)
            PH_HUNT:
            begin
                // only a byte with the top bit set opens a frame
                if (b[7])
                begin
                    run_sum  = b;
                    rx_phase = PH_LEN;
                end
                else
                    used = 1'b0;
            end
            PH_LEN:
            begin
                run_sum     = run_sum + b;
                bytes_left  = b;
                bit_acc     = 15'd0;
                bits_in_acc = 3'd0;
                sign_bit    = 1'b0;
                word_fill   = 0;
                got_payload = 1'b0;
                rx_phase    = (b == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA:
            begin
                // whole byte counts toward the sum, low 7 bits get packed
                run_sum     = run_sum + b;
                got_payload = 1'b1;
                sign_bit    = b[6];
                bit_acc     = bit_acc | ({8'd0, b[6:0]} << bits_in_acc);
                held_now    = int'(bits_in_acc) + 7;
                if (held_now >= 8)
                begin
                    push_decoded(bit_acc[7:0], 1'b1, 1'b0, 1'b0);
                    bit_acc  = bit_acc >> 8;
                    held_now = held_now - 8;
                    if (word_fill < WORD_BYTES_DEF)
                        word_fill++;
                end
                bits_in_acc = held_now[2:0];
                bytes_left  = bytes_left - 8'd1;
                if (bytes_left == 8'd0)
                    rx_phase = PH_CHECK;
            end
            default:
            begin
                // checksum compared in full, so bit 7 set never matches
                want     = (8'd0 - run_sum) & 8'h7F;
                rx_phase = PH_HUNT;
                if (b != want)
                    push_decoded(8'd0, 1'b0, 1'b1, 1'b0);
                else if (!got_payload)
                    push_decoded(8'd0, 1'b0, 1'b1, 1'b1);
                else
                begin
                    fill    = (pad && sign_bit) ? 8'hFF : 8'h00;
                    k       = 0;
                    emitted = word_fill;
                    if (bits_in_acc != 3'd0)
                    begin
                        outb[k] = bit_acc[7:0] | (fill << bits_in_acc);
                        k++;
                        emitted++;
                    end
                    if (pad)
                    begin
                        while (emitted < WORD_BYTES_DEF && k < RESULT_CAP)
                        begin
                            outb[k] = fill;
                            k++;
                            emitted++;
                        end
                    end
                    if (k == 0)
                        push_decoded(8'd0, 1'b0, 1'b1, 1'b1);
                    else
                    begin
                        for (i = 0; i < k; i++)
                            push_decoded(outb[i], 1'b1, i == k - 1, i == k - 1);
                    end
                    word_fill = (emitted > WORD_BYTES_DEF) ? WORD_BYTES_DEF : emitted;
                end
            end
        endcase
        return used;
    endfunction

    // ------------------------------------------------------------------
    // result side: ready pattern and checking
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected item: byte=%02h valid=%0b ok=%0b last=%0b",
                         $time, m_tdata, m_tuser[0], m_tuser[1], m_tlast);
                n_fail++;
            end
            else
            begin
                exp_r = decoded_q.pop_front();
                n_checked++;
                if (m_tdata !== exp_r.out_byte || m_tuser[0] !== exp_r.byte_valid ||
                    m_tuser[1] !== exp_r.frame_ok || m_tlast !== exp_r.frame_end)
                begin
                    $display({"%0t: item differs: expected byte=%02h valid=%0b ok=%0b ",
                              "last=%0b, got byte=%02h valid=%0b ok=%0b last=%0b"},
                             $time, exp_r.out_byte, exp_r.byte_valid, exp_r.frame_ok,
                             exp_r.frame_end, m_tdata, m_tuser[0], m_tuser[1], m_tlast);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    // offers one item, returns at the edge that takes it with valid still up
    task automatic send_item(input logic [7:0] b, input logic pad);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pad, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (deframe_step(b, pad))
            n_items++;
    endtask

    task automatic sender_rest();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // sender pauses until every decoded byte has come out
    task automatic wait_drained();
        sender_rest();
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    // start, length, payload, checksum; a nonzero sum_flip spoils the checksum
    task automatic send_frame(input logic [7:0] start_b, input byte_q_t payload,
                              input logic pad, input logic [7:0] sum_flip);
        logic [7:0] sum;
        int         i;
        sum = start_b + 8'(payload.size());
        send_item(start_b, 1'($urandom_range(0, 1)));
        send_item(8'(payload.size()), 1'($urandom_range(0, 1)));
        for (i = 0; i < payload.size(); i++)
        begin
            sum = sum + payload[i];
            send_item(payload[i], 1'($urandom_range(0, 1)));
        end
        send_item(((8'd0 - sum) & 8'h7F) ^ sum_flip, pad);
        n_frames++;
        if (sum_flip != 8'd0)
            n_bad_sums++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_hunting_noise();
        send_item(8'h00, 1'b0);
        send_item(8'h7F, 1'b1);
    endtask

    task automatic test_empty_frames();
        byte_q_t pl;
        pl.delete();
        // good empty frame in word mode still gives only a status item
        send_frame(8'h80, pl, 1'b1, 8'h00);
        // checksum with bit 7 set never matches
        send_frame(8'hFF, pl, 1'b0, 8'h80);
    endtask

    task automatic test_sign_fill();
        byte_q_t pl;
        // one payload byte with bit 6 set: tail plus three fill bytes
        pl = '{8'h7F};
        send_frame(8'hA5, pl, 1'b1, 8'h00);
    endtask

    task automatic test_exact_bytes();
        byte_q_t pl;
        // 8 x 7 bits make exactly 7 bytes; word already full, no tail left
        pl = '{8'hFF, 8'h80, 8'h00, 8'h55, 8'h2A, 8'hC0, 8'h01, 8'h7E};
        send_frame(8'hC3, pl, 1'b1, 8'h00);
        wait_drained();
    endtask

    // mostly good frames with random content, some noise and broken runs
    task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                      input int count);
        byte_q_t    pl;
        int         target;
        int         r;
        int         len;
        int         i;
        logic [7:0] flip;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target         = n_items + count;
        while (n_items < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                // link noise, dropped while hunting
                for (i = 0; i < $urandom_range(1, 3); i++)
                    send_item(8'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            end
            else if (r < 14)
            begin
                // garbage that may open a frame and swallow the next one
                for (i = 0; i < $urandom_range(1, 4); i++)
                    send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    len = 0;
                else if (r < 97)
                    len = $urandom_range(1, 12);
                else
                    len = $urandom_range(13, 40);
                pl.delete();
                for (i = 0; i < len; i++)
                    pl = {pl, 8'($urandom_range(0, 255))};
                flip = ($urandom_range(0, 99) < 10) ? 8'($urandom_range(1, 255)) : 8'h00;
                send_frame(8'h80 | 8'($urandom_range(0, 127)), pl,
                           1'($urandom_range(0, 1)), flip);
            end
        end
        wait_drained();
    endtask

    // the longest length the length byte allows
    task automatic test_longest_frame();
        byte_q_t pl;
        int      i;
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        pl.delete();
        for (i = 0; i < 255; i++)
            pl = {pl, 8'($urandom_range(0, 255))};
        send_frame(8'h80 | 8'($urandom_range(0, 127)), pl, 1'($urandom_range(0, 1)), 8'h00);
        wait_drained();
    endtask

    // output held off for a long stretch while the sender keeps going
    task automatic test_output_backpressure();
        byte_q_t    pl;
        logic [7:0] sum;
        int         i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pl.delete();
        for (i = 0; i < 40; i++)
            pl = {pl, 8'($urandom_range(0, 255))};
        sum = 8'h9C + 8'd40;
        send_item(8'h9C, 1'b0);
        send_item(8'd40, 1'b1);
        hold_left = 120;
        for (i = 0; i < pl.size(); i++)
        begin
            sum = sum + pl[i];
            send_item(pl[i], 1'($urandom_range(0, 1)));
        end
        send_item((8'd0 - sum) & 8'h7F, 1'b1);
        n_frames++;
        wait_drained();
        // one more frame right after the drain
        pl = '{8'h40, 8'h13, 8'h6A};
        send_frame(8'hB0, pl, 1'b1, 8'h00);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_hunting_noise();
        test_empty_frames();
        test_sign_fill();
        test_exact_bytes();

        test_random_frames(0, 0, 20);
        test_random_frames(84, 0, 20);
        test_random_frames(0, 84, 20);
        test_random_frames(38, 38, 20);
        test_longest_frame();
        test_output_backpressure();

        // settle, and catch any stray result items
        wait_drained();
        repeat (10) @(posedge clk);

        $display("ran %0d decoded input items over %0d frames (%0d with a bad checksum)",
                 n_items, n_frames, n_bad_sums);
        $display("checked %0d result items under idle, stall and hold-off mixes",
                 n_checked);
        if (n_fail == 0 && decoded_q.size() == 0)
            $display("seven_bit_frame_receiver: match");
        else
            $display("seven_bit_frame_receiver: mismatch");
        $finish;
    end

endmodule

// ===== seven_bit_frame_receiver.f =====
+incdir+src
src/sbfr_pkg.sv
src/sbfr_decode.sv
src/sbfr_outbuf.sv
src/seven_bit_frame_receiver.sv
tb/seven_bit_frame_receiver_tb.sv
